/* rtl/core/pmcf_pkg.sv */
`timescale 1ns / 1ps
// Package for the periodic mirror coordinate fold core.
// Holds payload structs, per-axis control struct and fold kind codes.
package pmcf_pkg;

	localparam int DIV_STEPS = 33;
	localparam int LAT       = DIV_STEPS + 2;

	localparam logic [1:0] KIND_PASS = 2'd0;
	localparam logic [1:0] KIND_SIGN = 2'd1;
	localparam logic [1:0] KIND_MIRR = 2'd2;
	localparam logic [1:0] KIND_WRAP = 2'd3;

	localparam logic [2:0] REG_MODES   = 3'd0;
	localparam logic [2:0] REG_LOWER_X = 3'd1;
	localparam logic [2:0] REG_UPPER_X = 3'd2;
	localparam logic [2:0] REG_LOWER_Y = 3'd3;
	localparam logic [2:0] REG_UPPER_Y = 3'd4;
	localparam logic [2:0] REG_LOWER_Z = 3'd5;
	localparam logic [2:0] REG_UPPER_Z = 3'd6;

	typedef struct packed {
		logic signed [31:0] coord_z;
		logic signed [31:0] coord_y;
		logic signed [31:0] coord_x;
	} in_t;

	typedef struct packed {
		logic               bad_period;
		logic signed [31:0] folded_z;
		logic signed [31:0] folded_y;
		logic signed [31:0] folded_x;
	} out_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic               neg;
		logic               bad;
		logic signed [32:0] d;
		logic [33:0]        p;
		logic signed [31:0] lo;
		logic signed [31:0] hi;
		logic signed [31:0] passval;
	} axis_ctl_t;

endpackage

/* rtl/core/pmcf_div_step.sv */
`timescale 1ns / 1ps
// One restoring remainder step of the per-axis modulo pipeline.
// Depends on pmcf_pkg for the axis control struct.
module pmcf_div_step import pmcf_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  axis_ctl_t   ctl_in,
	input  logic [33:0] rem_in,
	input  logic [32:0] mag_in,
	output axis_ctl_t   ctl_out,
	output logic [33:0] rem_out,
	output logic [32:0] mag_out
);

	logic [34:0] t;
	logic [34:0] pe;
	logic [34:0] rem_n;

	always_comb begin
		t     = {rem_in, mag_in[32]};
		pe    = {1'b0, ctl_in.p};
		rem_n = (t >= pe) ? (t - pe) : t;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_out <= ctl_in;
			rem_out <= rem_n[33:0];
			mag_out <= {mag_in[31:0], 1'b0};
		end
	end

endmodule

/* rtl/core/pmcf_axis.sv */
`timescale 1ns / 1ps
// Fold pipeline for one axis: setup stage, remainder chain, fixup stage.
// Depends on pmcf_pkg and pmcf_div_step.
module pmcf_axis import pmcf_pkg::*; (
	input  logic               clk,
	input  logic               en,
	input  logic signed [31:0] x,
	input  logic [2:0]         modes,
	input  logic signed [31:0] lo,
	input  logic signed [31:0] hi,
	output logic signed [31:0] folded,
	output logic               bad
);

	logic               per, sym, ign;
	logic signed [32:0] xs, ax, d, n;
	logic [32:0]        mag;
	axis_ctl_t          ctl;

	always_comb begin
		per = modes[0];
		sym = modes[1];
		ign = modes[2];
		xs  = {x[31], x};
		ax  = xs[32] ? -xs : xs;
		d   = {hi[31], hi} - {lo[31], lo};
		ctl.bad = per & (d <= 0);
		ctl.d   = d;
		ctl.lo  = lo;
		ctl.hi  = hi;
		if (!per || ctl.bad) ctl.kind = KIND_PASS;
		else if (sym && ign) ctl.kind = KIND_SIGN;
		else if (sym)        ctl.kind = KIND_MIRR;
		else                 ctl.kind = KIND_WRAP;
		if (!per && sym && !ign) ctl.passval = ax[31] ? 32'sh7fffffff : ax[31:0];
		else                     ctl.passval = x;
		case (ctl.kind)
			KIND_SIGN: n = xs;
			KIND_MIRR: n = ax;
			KIND_WRAP: n = xs - {lo[31], lo};
			default:   n = '0;
		endcase
		ctl.neg = n[32] & (ctl.kind != KIND_MIRR);
		mag     = ctl.neg ? 33'(-n) : 33'(n);
		case (ctl.kind)
			KIND_WRAP: ctl.p = {1'b0, d};
			KIND_PASS: ctl.p = 34'd1;
			default:   ctl.p = {d, 1'b0};
		endcase
	end

	axis_ctl_t   ctl_c [DIV_STEPS+1];
	logic [33:0] rem_c [DIV_STEPS+1];
	logic [32:0] mag_c [DIV_STEPS+1];

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_c[0] <= ctl;
			rem_c[0] <= '0;
			mag_c[0] <= mag;
		end
	end

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
		pmcf_div_step u_step (
			.clk     (clk),
			.en      (en),
			.ctl_in  (ctl_c[k]),
			.rem_in  (rem_c[k]),
			.mag_in  (mag_c[k]),
			.ctl_out (ctl_c[k+1]),
			.rem_out (rem_c[k+1]),
			.mag_out (mag_c[k+1])
		);
	end

	axis_ctl_t          cf;
	logic signed [35:0] r, d36, p36, res;

	always_comb begin
		cf  = ctl_c[DIV_STEPS];
		r   = cf.neg ? -$signed({2'b00, rem_c[DIV_STEPS]}) : $signed({2'b00, rem_c[DIV_STEPS]});
		d36 = {{3{cf.d[32]}}, cf.d};
		p36 = $signed({2'b00, cf.p});
		case (cf.kind)
			KIND_SIGN: begin
				if (r > d36)       res = r - p36;
				else if (r < -d36) res = r + p36;
				else               res = r;
			end
			KIND_MIRR: begin
				res = (r > d36) ? (p36 - r) : r;
				if (res > 36'sh7fffffff) res = 36'sh7fffffff;
			end
			KIND_WRAP: res = r[35] ? (r + {{4{cf.hi[31]}}, cf.hi})
			                       : (r + {{4{cf.lo[31]}}, cf.lo});
			default:   res = {{4{cf.passval[31]}}, cf.passval};
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			folded <= res[31:0];
			bad    <= cf.bad;
		end
	end

endmodule

/* rtl/core/periodic_mirror_coordinate_fold_core.sv */
`timescale 1ns / 1ps
// Periodic mirror coordinate fold core, top level.
// Depends on pmcf_pkg and pmcf_axis.
//
// Input channel in_valid/in_ready/in_data carries one point request of
// Q16.16 coordinates; output channel out_valid/out_ready/out_data returns
// the folded point and a bad_period flag, one result per request, in order.
// Configuration: cfg_wen/cfg_index/cfg_data writes register cfg_index at
// the clock edge; index 0 is the mode word, 1..6 are lower/upper x,y,z.
// Write only while no request is in flight.
// The pipeline is one setup stage, 33 restoring remainder stages
// (one quotient bit each, against the 34-bit period) and one fixup stage.
// Throughput is one point per cycle while the receiver is not stalling.
// Reset clears the valid pipeline and restores the register defaults.
// When the receiver stalls with a result waiting, the whole pipeline
// holds and in_ready drops; nothing is lost or repeated.
module periodic_mirror_coordinate_fold_core import pmcf_pkg::*; #(
	parameter int AXES = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_t         in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_t        out_data,
	input  logic        cfg_wen,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	logic [8:0]         modes_q;
	logic signed [31:0] lower_q [3];
	logic signed [31:0] upper_q [3];
	logic [LAT-1:0]     valid_q;
	logic               en;

	assign en        = !valid_q[LAT-1] || out_ready;
	assign in_ready  = en;
	assign out_valid = valid_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modes_q <= '0;
			for (int i = 0; i < 3; i++) begin
				lower_q[i] <= 32'sd0;
				upper_q[i] <= 32'sd65536;
			end
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_MODES:   modes_q    <= cfg_data[8:0];
				REG_LOWER_X: lower_q[0] <= cfg_data;
				REG_UPPER_X: upper_q[0] <= cfg_data;
				REG_LOWER_Y: lower_q[1] <= cfg_data;
				REG_UPPER_Y: upper_q[1] <= cfg_data;
				REG_LOWER_Z: lower_q[2] <= cfg_data;
				REG_UPPER_Z: upper_q[2] <= cfg_data;
				default:     ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (en) begin
			valid_q <= {valid_q[LAT-2:0], in_valid};
		end
	end

	logic signed [31:0] coord  [3];
	logic signed [31:0] folded [3];
	logic [2:0]         bad;

	assign coord[0] = in_data.coord_x;
	assign coord[1] = in_data.coord_y;
	assign coord[2] = in_data.coord_z;

	for (genvar i = 0; i < 3; i++) begin : g_axis
		if (i < AXES) begin : g_on
			pmcf_axis u_axis (
				.clk    (clk),
				.en     (en),
				.x      (coord[i]),
				.modes  (modes_q[3*i +: 3]),
				.lo     (lower_q[i]),
				.hi     (upper_q[i]),
				.folded (folded[i]),
				.bad    (bad[i])
			);
		end else begin : g_off
			assign folded[i] = 32'sd0;
			assign bad[i]    = 1'b0;
		end
	end

	assign out_data.folded_x   = folded[0];
	assign out_data.folded_y   = folded[1];
	assign out_data.folded_z   = folded[2];
	assign out_data.bad_period = |bad;

endmodule

/* rtl/core/pmcf_checker.sv */
`timescale 1ns / 1ps
// Port-level checker for the fold core, bound to the top level.
// Depends on pmcf_pkg for the payload types.
module pmcf_checker import pmcf_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input in_t  in_data,
	input logic out_valid,
	input logic out_ready,
	input out_t out_data
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_data))
		else $error("result changed while stalled");

	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("request ready does not follow output stall");

	a_no_flag_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("request refused with output empty");

endmodule

bind periodic_mirror_coordinate_fold_core pmcf_checker u_pmcf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
